@@ src/snrf_pkg.sv @@
// ----------------------------------------------------------------------------
// snrf_pkg: shared types and constants
// Field widths, register indexes, the queue entry type and the back-end state
// type of the nerve response filter.
// ----------------------------------------------------------------------------
`default_nettype none
package snrf_pkg;

   localparam int GRAD_BITS   = 24;
   localparam int TAG_BITS    = 16;
   localparam int RESP_BITS   = 24;
   localparam int CNT_BITS    = 32;
   localparam int FLAG_BITS   = 4;
   localparam int WEIGHT_BITS = 20;
   localparam int WEIGHT_FRAC = 16;
   localparam int STAGES      = 3;
   localparam int ALPHA_BITS  = 48;
   localparam int WREG_BITS   = 60;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ALPHA_X   = 3'd0,
      REG_ALPHA_Y   = 3'd1,
      REG_ALPHA_Z   = 3'd2,
      REG_WEIGHTS_X = 3'd3,
      REG_WEIGHTS_Y = 3'd4,
      REG_WEIGHTS_Z = 3'd5
   } reg_index_type;

   // Entry passed from the front end to the back end.
   typedef struct packed {
      logic signed [GRAD_BITS:0] slew_x;
      logic signed [GRAD_BITS:0] slew_y;
      logic signed [GRAD_BITS:0] slew_z;
      logic [TAG_BITS-1:0]       tag;
      logic [CNT_BITS-1:0]       index;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT,
      ST_SUM,
      ST_SQRT,
      ST_DONE
   } back_state_type;

endpackage
`default_nettype wire

@@ src/snrf_if.sv @@
// ----------------------------------------------------------------------------
// snrf_req_if / snrf_rsp_if / snrf_csr_if: channel interfaces
// Valid/ready channels carrying the sample, the result and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface snrf_req_if import snrf_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [GRAD_BITS-1:0] grad_x;
   logic signed [GRAD_BITS-1:0] grad_y;
   logic signed [GRAD_BITS-1:0] grad_z;
   logic [TAG_BITS-1:0] block_id;
   modport source (output valid, grad_x, grad_y, grad_z, block_id, input ready);
   modport sink (input valid, grad_x, grad_y, grad_z, block_id, output ready);
endinterface

interface snrf_rsp_if import snrf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CNT_BITS-1:0] sample_index;
   logic [TAG_BITS-1:0] block_tag;
   logic [RESP_BITS-1:0] resp_x;
   logic [RESP_BITS-1:0] resp_y;
   logic [RESP_BITS-1:0] resp_z;
   logic [RESP_BITS-1:0] resp_norm;
   logic [FLAG_BITS-1:0] peak_flags;
   modport source (output valid, sample_index, block_tag, resp_x, resp_y, resp_z,
                   resp_norm, peak_flags, input ready);
   modport sink (input valid, sample_index, block_tag, resp_x, resp_y, resp_z,
                 resp_norm, peak_flags, output ready);
endinterface

interface snrf_csr_if import snrf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/safe_nerve_response_filter.sv @@
// Path from transaction accept to result when the engine is idle and the
// result side is ready: the idle state, one filter stage per cycle, the
// summing state, the bit-serial square root and the output register.
// The engine works on one transaction at a time; a stalled result holds the
// engine, and the front end queue holds up to two samples, its current one included.
// Reset: synchronous, active high; clears all filter state, peaks, counts
// and registers.
// ----------------------------------------------------------------------------
// safe_nerve_response_filter: three-axis nerve stimulation response filter
// Front end forms slews; the back end runs the low-pass stages and the norm.
// ----------------------------------------------------------------------------
`default_nettype none
module safe_nerve_response_filter import snrf_pkg::*; #(
   parameter int NUM_AXES   = 3,
   parameter int COEF_BITS  = 16,
   parameter int STATE_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   snrf_req_if.sink   req,
   snrf_rsp_if.source rsp,
   snrf_csr_if.sink   csr
);
   logic [ALPHA_BITS-1:0] alpha_ff [3];
   logic [WREG_BITS-1:0]  weights_ff [3];
   work_type head;
   logic head_valid, head_pop;

   // Register writes are always taken; indexes beyond the list are dropped.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            alpha_ff[a] <= '0;
            weights_ff[a] <= '0;
         end
      end else if (csr.valid) begin
         unique case (reg_index_type'(csr.index))
            REG_ALPHA_X:   alpha_ff[0] <= csr.data[ALPHA_BITS-1:0];
            REG_ALPHA_Y:   alpha_ff[1] <= csr.data[ALPHA_BITS-1:0];
            REG_ALPHA_Z:   alpha_ff[2] <= csr.data[ALPHA_BITS-1:0];
            REG_WEIGHTS_X: weights_ff[0] <= csr.data[WREG_BITS-1:0];
            REG_WEIGHTS_Y: weights_ff[1] <= csr.data[WREG_BITS-1:0];
            REG_WEIGHTS_Z: weights_ff[2] <= csr.data[WREG_BITS-1:0];
            default: ;
         endcase
      end
   end

   snrf_front u_front (
      .clock, .reset, .req, .head, .head_valid, .head_pop
   );

   snrf_back #(
      .NUM_AXES(NUM_AXES), .COEF_BITS(COEF_BITS), .STATE_BITS(STATE_BITS)
   ) u_back (
      .clock, .reset, .alpha(alpha_ff), .weights(weights_ff),
      .head, .head_valid, .head_pop, .rsp
   );
endmodule
`default_nettype wire

@@ src/snrf_front.sv @@
// ----------------------------------------------------------------------------
// snrf_front: sample intake
// Forms the per-axis slew from the previous sample, stamps the sample index
// and pushes one entry into a two-deep queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module snrf_front import snrf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   snrf_req_if.sink  req,
   output work_type  head,
   output logic      head_valid,
   input  wire logic head_pop
);
   logic signed [GRAD_BITS-1:0] prev_ff [3];
   logic [CNT_BITS-1:0] count_ff;
   work_type q_ff [2];
   logic [1:0] fill_ff;
   logic push;
   work_type entry;

   assign req.ready  = (fill_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign head       = q_ff[0];
   assign head_valid = (fill_ff != 2'd0);

   always_comb begin
      entry.slew_x = (GRAD_BITS+1)'(req.grad_x) - (GRAD_BITS+1)'(prev_ff[0]);
      entry.slew_y = (GRAD_BITS+1)'(req.grad_y) - (GRAD_BITS+1)'(prev_ff[1]);
      entry.slew_z = (GRAD_BITS+1)'(req.grad_z) - (GRAD_BITS+1)'(prev_ff[2]);
      entry.tag    = req.block_id;
      entry.index  = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff[0] <= '0;
         prev_ff[1] <= '0;
         prev_ff[2] <= '0;
         count_ff   <= '0;
         fill_ff    <= '0;
      end else begin
         if (push) begin
            prev_ff[0] <= req.grad_x;
            prev_ff[1] <= req.grad_y;
            prev_ff[2] <= req.grad_z;
            count_ff   <= count_ff + 1'b1;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, head_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         q_ff[0] <= (fill_ff == 2'd2) ? q_ff[1] : entry;
         if (fill_ff == 2'd2 && push) q_ff[1] <= entry;
      end else if (push) begin
         if (fill_ff == 2'd0) q_ff[0] <= entry;
         else q_ff[1] <= entry;
      end
   end
endmodule
`default_nettype wire

@@ src/snrf_back.sv @@
// ----------------------------------------------------------------------------
// snrf_back: filter, weighting and norm engine
// Steps the nine low-pass stages one per cycle through a shared multiplier,
// weighs their magnitudes, then takes a bit-serial integer square root.
// ----------------------------------------------------------------------------
`default_nettype none
module snrf_back import snrf_pkg::*; #(
   parameter int NUM_AXES   = 3,
   parameter int COEF_BITS  = 16,
   parameter int STATE_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [ALPHA_BITS-1:0] alpha [3],
   input  wire logic [WREG_BITS-1:0]  weights [3],
   input  work_type  head,
   input  wire logic head_valid,
   output logic      head_pop,
   snrf_rsp_if.source rsp
);
   localparam int SB = STATE_BITS;
   localparam int PW = SB + 2 + COEF_BITS;   // product width
   localparam int WPW = SB + WEIGHT_BITS;
   localparam int SQ_BITS = 2 * RESP_BITS + 2;
   localparam logic signed [SB:0] S_HI = (SB+1)'((64'd1 << (SB-1)) - 64'd1);
   localparam logic signed [SB:0] S_LO = ~S_HI;
   localparam logic [RESP_BITS:0] CAP = (RESP_BITS+1)'(1) << RESP_BITS;

   back_state_type state_ff, state_in;
   logic signed [SB-1:0] filt_ff [3][STAGES];
   logic [RESP_BITS-1:0] peak_ff [3];
   logic [RESP_BITS-1:0] peakn_ff;
   logic [1:0] ax_ff, st_ff;
   logic [RESP_BITS+2:0] sum_ff;
   logic [RESP_BITS-1:0] resp_ff [3];
   logic [SQ_BITS-1:0] sq_ff, rem_ff, root_ff;
   logic [4:0] sbit_ff;
   logic [FLAG_BITS-1:0] flags_ff;
   logic signed [SB-1:0] slew_c [3];
   logic [SB-1:0] wmag_ff;
   logic [WEIGHT_BITS-1:0] wsel_ff;
   logic wvld_ff;

   // Slew clamped to the state range.
   always_comb begin
      logic signed [GRAD_BITS:0] sv [3];
      sv[0] = head.slew_x; sv[1] = head.slew_y; sv[2] = head.slew_z;
      for (int a = 0; a < 3; a++) begin
         if ((SB+1)'(sv[a]) > S_HI)      slew_c[a] = S_HI[SB-1:0];
         else if ((SB+1)'(sv[a]) < S_LO) slew_c[a] = S_LO[SB-1:0];
         else                            slew_c[a] = SB'(sv[a]);
      end
   end

   // Current filter stage update. The rectified stage input is one bit wider
   // so that the magnitude of the most negative slew is kept exactly.
   logic signed [SB-1:0] s_cur, s_new;
   logic signed [SB:0] x_cur;
   logic signed [SB+1:0] diff;
   logic [COEF_BITS-1:0] al;
   logic [PW-1:0] prod_mag;
   logic [SB+1:0] dmag;
   logic signed [SB+1:0] s_sum;
   logic signed [SB+1:0] step;
   logic [SB-1:0] s_abs;
   always_comb begin
      s_cur = filt_ff[ax_ff][st_ff];
      x_cur = (SB+1)'(slew_c[ax_ff]);
      if (st_ff == 2'd1 && slew_c[ax_ff] < 0) x_cur = -x_cur;
      diff = (SB+2)'(x_cur) - (SB+2)'(s_cur);
      al = ((st_ff * COEF_BITS) < ALPHA_BITS)
           ? COEF_BITS'(alpha[ax_ff] >> (st_ff * COEF_BITS)) : '0;
      dmag = diff[SB+1] ? (SB+2)'(-diff) : (SB+2)'(diff);
      prod_mag = PW'(dmag) * PW'(al);
      step = (SB+2)'(prod_mag >> COEF_BITS);
      if (diff[SB+1]) step = -step;
      s_sum = (SB+2)'(s_cur) + step;
      if (s_sum > (SB+2)'(S_HI))      s_new = S_HI[SB-1:0];
      else if (s_sum < (SB+2)'(S_LO)) s_new = S_LO[SB-1:0];
      else                            s_new = SB'(s_sum);
      s_abs = s_new[SB-1] ? SB'(-s_new) : SB'(s_new);
   end

   // Weighting product of the registered magnitude and weight, one stage behind the filter.
   logic [WPW-1:0] wprod;
   logic [RESP_BITS:0] wterm;
   always_comb begin
      wprod = WPW'(wmag_ff) * WPW'(wsel_ff);
      wterm = ((wprod >> WEIGHT_FRAC) > WPW'(CAP)) ? CAP
              : (RESP_BITS+1)'(wprod >> WEIGHT_FRAC);
   end

   logic last_stage;
   assign last_stage = (st_ff == 2'(STAGES-1)) && (ax_ff == 2'(NUM_AXES-1));

   // Square-root step.
   logic [SQ_BITS-1:0] sbit, trial;
   assign sbit  = SQ_BITS'(1) << {sbit_ff, 1'b0};
   assign trial = root_ff + sbit;

   logic [RESP_BITS+2:0] sum_next;
   assign sum_next = sum_ff + (wvld_ff ? (RESP_BITS+3)'(wterm) : '0);
   logic [RESP_BITS-1:0] resp_cur;
   assign resp_cur = (sum_next > (RESP_BITS+3)'(CAP - 1'b1)) ? '1
                     : RESP_BITS'(sum_next);

   always_comb begin
      state_in = state_ff;
      head_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (head_valid) state_in = ST_FILT;
         ST_FILT: if (last_stage) state_in = ST_SUM;
         ST_SUM:  state_in = ST_SQRT;
         ST_SQRT: if (sbit_ff == 5'd0) state_in = ST_DONE;
         ST_DONE: if (!rsp.valid || rsp.ready) begin
            state_in = ST_IDLE;
            head_pop = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp.valid <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            peak_ff[a] <= '0;
            for (int k = 0; k < STAGES; k++) filt_ff[a][k] <= '0;
         end
         peakn_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready && state_ff != ST_DONE) rsp.valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               ax_ff <= '0; st_ff <= '0; sum_ff <= '0; wvld_ff <= 1'b0;
               flags_ff <= '0;
               for (int a = 0; a < 3; a++) resp_ff[a] <= '0;
            end
            ST_FILT, ST_SUM: begin
               if (state_ff == ST_FILT) begin
                  filt_ff[ax_ff][st_ff] <= s_new;
                  wmag_ff <= s_abs;
                  wsel_ff <= WEIGHT_BITS'(weights[ax_ff] >> (st_ff * WEIGHT_BITS));
                  wvld_ff <= 1'b1;
               end else wvld_ff <= 1'b0;
               // Weight term of the previous cycle closes an axis after stage 2.
               // In the summing cycle this closes the last active axis.
               if (wvld_ff && st_ff == 2'd0) begin
                  logic [1:0] pa;
                  pa = ax_ff - 2'd1;
                  resp_ff[pa] <= resp_cur;
                  if (resp_cur > peak_ff[pa]) begin
                     peak_ff[pa] <= resp_cur;
                     flags_ff[pa] <= 1'b1;
                  end
                  sum_ff <= '0;
               end else sum_ff <= sum_next;
               if (state_ff == ST_FILT) begin
                  if (st_ff == 2'(STAGES-1)) begin
                     st_ff <= '0; ax_ff <= ax_ff + 2'd1;
                  end else st_ff <= st_ff + 2'd1;
               end
               if (state_ff == ST_SUM) begin
                  sbit_ff <= 5'(RESP_BITS + 1);
                  root_ff <= '0;
               end
            end
            ST_SQRT: begin
               if (sbit_ff == 5'(RESP_BITS + 1)) begin
                  // squares summed in first sqrt cycle, one multiplier each
                  rem_ff <= SQ_BITS'(resp_ff[0]) * SQ_BITS'(resp_ff[0])
                          + SQ_BITS'(resp_ff[1]) * SQ_BITS'(resp_ff[1])
                          + SQ_BITS'(resp_ff[2]) * SQ_BITS'(resp_ff[2]);
               end else if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  root_ff <= (root_ff >> 1) + sbit;
               end else root_ff <= root_ff >> 1;
               sbit_ff <= sbit_ff - 5'd1;
            end
            ST_DONE: if (!rsp.valid || rsp.ready) begin
               logic [RESP_BITS-1:0] n;
               n = (root_ff > SQ_BITS'(CAP - 1'b1)) ? '1 : RESP_BITS'(root_ff);
               rsp.valid <= 1'b1;
               rsp.sample_index <= head.index;
               rsp.block_tag <= head.tag;
               rsp.resp_x <= resp_ff[0];
               rsp.resp_y <= resp_ff[1];
               rsp.resp_z <= resp_ff[2];
               rsp.resp_norm <= n;
               rsp.peak_flags <= {n > peakn_ff, flags_ff[2:0]};
               if (n > peakn_ff) peakn_ff <= n;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
